// File: design/btos_pkg.sv
// Package for the buffered trace solver: widths, mode codes and word types.
// Used by the in/out channel interfaces, the weight divider and top level.
package btos_pkg;
	localparam int FLOWS = 32;
	localparam int FLOW_W = 5;
	localparam int ADDR_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;
	localparam int WBITS = 24;
	localparam logic [1:0] MODE_FULL = 2'd0;
	localparam logic [1:0] MODE_NO_RED = 2'd1;
	localparam logic [1:0] MODE_RED_ONLY = 2'd2;

	typedef struct packed {
		logic [FLOW_W-1:0] flow_index;
		logic first_frame;
		logic [23:0] frame_interval;
		logic [23:0] time_constant;
		logic signed [15:0] buffer_ratio;
		logic signed [31:0] red_sample;
		logic signed [31:0] blue_sample;
	} in_word_t;

	typedef struct packed {
		logic [FLOW_W-1:0] flow_tag;
		logic signed [31:0] trace_value;
		logic saturated;
	} out_word_t;

	typedef struct packed {
		logic signed [31:0] last_output;
		logic signed [31:0] last_red;
		logic signed [31:0] last_blue;
	} hist_t;
endpackage

// File: design/btos_in_if.sv
// Input channel interface carrying one frame sample word.
// Depends on btos_pkg.
interface btos_in_if;
	logic valid;
	logic ready;
	btos_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/btos_out_if.sv
// Output channel interface carrying one solved trace word.
// Depends on btos_pkg.
interface btos_out_if;
	logic valid;
	logic ready;
	btos_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/btos_cfg_if.sv
// Configuration write channel carrying the solve mode.
// Depends on nothing.
interface btos_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/btos_div.sv
// Restoring divider for the weight w = round(2 tau 2^24 / (2 tau + dt)).
// Depends on btos_pkg; one quotient bit per cycle.
module btos_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [23:0] tau,
	input logic [23:0] dt,
	output logic done,
	output logic [24:0] quot
);
	import btos_pkg::*;

	logic [25:0] den_q;
	logic [50:0] num_q;
	logic [26:0] rem_q;
	logic [24:0] quot_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [26:0] trial;
	logic [26:0] diff;

	assign trial = {rem_q[25:0], num_q[50]};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd51;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= {1'b0, tau, 1'b0} + {2'b0, dt};
			num_q <= {2'b0, tau, 25'd0} + {27'd0, tau} + {28'd0, dt[23:1]};
			rem_q <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[49:0], 1'b0};
			if (!diff[26]) begin
				rem_q <= diff;
				quot_q <= {quot_q[23:0], 1'b1};
			end else begin
				rem_q <= trial;
				quot_q <= {quot_q[23:0], 1'b0};
			end
		end
	end

	assign quot = quot_q;
endmodule

// File: design/buffered_trace_ode_solver.sv
// Top level of the buffered trace solver: per-flow trapezoidal recursion.
// Depends on btos_pkg, the channel interfaces and btos_div.
//
// Usage: frame sample words arrive on in_ch; each carries a flow index,
// a restart mark, dt, tau, etbr and red/blue samples. One result word per
// input leaves on out_ch with the flow tag, the Q16.16 trace value and a
// saturation flag. The user must write the solve mode on cfg_ch only
// while the block is idle; the block does not enforce this. Per-flow
// history (last output, red, blue) sits in one synchronous memory.
// Because the memory has no reset, a valid bit per flow marks history
// written since reset; an unwritten flow reads as zero.
// After an input is accepted, the weight divider forms the weight one
// quotient bit at a time, followed by the etbr product, the two weight
// products, rounding with the history write-back and the output load. One
// item is in work at a time; the next item is accepted while a result
// waits in the output register, and when the receiver stalls, that item
// holds before the output load until the word is taken.
// Reset clears the mode, the valid bits and all control state.
module buffered_trace_ode_solver (
	input logic clk,
	input logic arst_n,
	btos_in_if.sink in_ch,
	btos_out_if.source out_ch,
	btos_cfg_if.sink cfg_ch
);
	import btos_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV = 3'd1;
	localparam logic [2:0] ST_MUL = 3'd2;
	localparam logic [2:0] ST_SUM = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;
	localparam logic [2:0] ST_PROD = 3'd5;

	logic [2:0] state_q;
	logic [1:0] mode_q;
	logic [FLOWS-1:0] vld_q;
	hist_t mem [FLOWS];
	hist_t rd_q;
	in_word_t item_q;
	logic [ADDR_W-1:0] addr;
	logic div_done;
	logic [24:0] w_raw;
	logic [24:0] w_q;
	logic rd_vld_q;
	logic signed [33:0] pr, pb, po;
	logic signed [50:0] ebp_s1;
	logic signed [35:0] eb;
	logic signed [36:0] a_v;
	logic signed [35:0] bt_v;
	logic signed [63:0] pa_s2, pb_s2;
	logic signed [65:0] sum;
	logic signed [41:0] res;
	logic signed [31:0] sat_v;
	logic sat_f;
	logic out_valid_q;
	out_word_t out_q;
	logic accept;
	logic out_load;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready = 1'b1;
	assign addr = item_q.flow_index[ADDR_W-1:0];
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);

	btos_div u_div (
		.clk(clk), .arst_n(arst_n), .start(accept),
		.tau(in_ch.data.time_constant), .dt(in_ch.data.frame_interval),
		.done(div_done), .quot(w_raw)
	);

	always_ff @(posedge clk) begin
		rd_q <= mem[addr];
		if (state_q == ST_SUM)
			mem[addr] <= '{last_output: sat_v, last_red: item_q.red_sample,
				last_blue: item_q.blue_sample};
	end

	always_comb begin
		if (item_q.first_frame || !rd_vld_q) begin
			pr = '0; pb = '0; po = '0;
		end else begin
			pr = 34'(rd_q.last_red);
			pb = 34'(rd_q.last_blue);
			po = 34'(rd_q.last_output);
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_q <= in_ch.data;
		if (div_done)
			w_q <= (item_q.time_constant == 24'd0) ? 25'd0 : w_raw;
		if (state_q == ST_MUL)
			ebp_s1 <= 51'(item_q.buffer_ratio) * 51'(34'(item_q.blue_sample) - pb);
		if (state_q == ST_PROD) begin
			pa_s2 <= 64'($signed({1'b0, w_q})) * 64'(a_v);
			pb_s2 <= 64'($signed({1'b0, 25'h1000000 - w_q})) * 64'(bt_v);
		end
		if (out_load) begin
			out_q.flow_tag <= item_q.flow_index;
			out_q.trace_value <= sat_v;
			out_q.saturated <= sat_f;
		end
	end

	// Keep mode fixed in work (unchecked); terms combine ahead of products.
	always_comb begin
		eb = 36'((ebp_s1 + 51'sd8192) >>> 14);
		if (mode_q == MODE_RED_ONLY)
			eb = '0;
		a_v = 37'(po) + 37'(eb);
		if (mode_q != MODE_NO_RED)
			a_v = a_v + 37'(34'(item_q.red_sample) - pr);
		if (mode_q == MODE_RED_ONLY)
			bt_v = -36'(po);
		else
			bt_v = 36'(item_q.blue_sample) + 36'(pb) - 36'(po);
		sum = 66'(pa_s2) + 66'(pb_s2) + 66'sd8388608;
		res = 42'(sum >>> WBITS);
		sat_f = (res > 42'sd2147483647) || (res < -42'sd2147483648);
		if (res > 42'sd2147483647)
			sat_v = 32'h7fffffff;
		else if (res < -42'sd2147483648)
			sat_v = 32'h80000000;
		else
			sat_v = res[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= MODE_FULL;
			vld_q <= '0;
			rd_vld_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready)
				mode_q <= cfg_ch.data;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready)
				out_valid_q <= 1'b0;
			rd_vld_q <= vld_q[addr];
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_DIV;
				ST_DIV: if (div_done) state_q <= ST_MUL;
				ST_MUL: state_q <= ST_PROD;
				ST_PROD: state_q <= ST_SUM;
				ST_SUM: begin
					vld_q[addr] <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_DIV) else $error("accept did not start work");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ch.ready) else $error("ready while busy");
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUM |=> vld_q[$past(addr)]) else $error("history not marked");
endmodule
